### rtl/pulse_width_qualifier_autocal_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the pulse width qualifier
// Short wrappers for clocked implication properties with asynchronous reset.
// ---------------------------------------------------------------------------
`ifndef PULSE_WIDTH_QUALIFIER_AUTOCAL_MACROS_SVH
`define PULSE_WIDTH_QUALIFIER_AUTOCAL_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PWQA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("pulse width qualifier: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PWQA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("pulse width qualifier: next-cycle check failed");

`endif

### rtl/pwqa_pkg.sv
// ---------------------------------------------------------------------------
// pwqa_pkg
// Shared widths, register indexes, reset values and event codes.
// ---------------------------------------------------------------------------
package pwqa_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned EventW  = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgCalWindow  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgStatPeriod = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgMinPulse   = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgMaxPulse   = 8'd3;

  // Reset values of the configuration registers.
  localparam logic [DataW-1:0] CalWindowRst  = 32'd1000;
  localparam logic [DataW-1:0] StatPeriodRst = 32'd1000;
  localparam logic [DataW-1:0] MinPulseRst   = 32'd300;
  localparam logic [DataW-1:0] MaxPulseRst   = 32'd100000;

  // Pulse event codes.
  localparam logic [EventW-1:0] EvNone   = 2'd0;
  localparam logic [EventW-1:0] EvAccept = 2'd1;
  localparam logic [EventW-1:0] EvReject = 2'd2;

endpackage

### rtl/pulse_width_qualifier_autocal.sv
// ---------------------------------------------------------------------------
// pulse_width_qualifier_autocal
// Pulse width discriminator that learns the idle level of its sensor.
// ---------------------------------------------------------------------------
// Usage: each input beat carries one sensor sample (sample_level_i) stamped
// with a millisecond time and a microsecond time. Every input beat produces
// exactly one output beat with the calibration state, the pulse verdict, the
// running counters and the status flag.
// Both channels use valid and stall: a beat moves on a rising edge where
// valid is high and stall is low.
// A sample is first held in the input register; the evaluation stage then
// updates the state and loads the output register, from where the result
// beat is offered. Throughput is one beat per cycle while the output is not
// stalled, set by that single evaluation stage; the state feeds back only
// through flip-flops, so a new sample may follow in every such cycle.
// When the receiver stalls, the output beat holds and the input register
// keeps one further sample; the input channel stalls only while both are
// full and the output stays stalled.
// Reset clears all state and counters and restores the default window,
// status period and pulse limits. Configuration writes are taken at once and
// are meant to be made only while the block is idle.
// ---------------------------------------------------------------------------
module pulse_width_qualifier_autocal
  import pwqa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [DataW-1:0]    cfg_wdata_i,
  // Sample channel.
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                sample_level_i,
  input  logic [DataW-1:0]    time_ms_i,
  input  logic [DataW-1:0]    time_us_i,
  // Result channel.
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                is_calibrated_o,
  output logic                idle_is_high_o,
  output logic [EventW-1:0]   pulse_event_o,
  output logic [DataW-1:0]    pulse_width_us_o,
  output logic [DataW-1:0]    accepted_count_o,
  output logic [DataW-1:0]    rejected_count_o,
  output logic [DataW-1:0]    edge_count_o,
  output logic                status_due_o
);

  // Configuration registers.
  logic [DataW-1:0] cal_window_q, stat_period_q, min_pulse_q, max_pulse_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_window_q  <= CalWindowRst;
      stat_period_q <= StatPeriodRst;
      min_pulse_q   <= MinPulseRst;
      max_pulse_q   <= MaxPulseRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgCalWindow:  cal_window_q  <= cfg_wdata_i;
        CfgStatPeriod: stat_period_q <= cfg_wdata_i;
        CfgMinPulse:   min_pulse_q   <= cfg_wdata_i;
        CfgMaxPulse:   max_pulse_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake. The evaluation stage fires whenever the input register holds
  // a sample and the output register is free or being emptied this cycle.
  logic             s1_valid_q;
  logic             out_valid_q;
  logic             out_free;
  logic             eval_fire;
  logic             in_accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign eval_fire  = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Input register.
  logic             s1_level_q;
  logic [DataW-1:0] s1_ms_q, s1_us_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (eval_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_level_q <= sample_level_i;
      s1_ms_q    <= time_ms_i;
      s1_us_q    <= time_us_i;
    end
  end

  // Block state.
  logic             started_q, started_d;
  logic             calibrated_q, calibrated_d;
  logic             last_level_q, last_level_d;
  logic             idle_high_q, idle_high_d;
  logic             in_pulse_q, in_pulse_d;
  logic [DataW-1:0] cal_start_q, cal_start_d;
  logic [DataW-1:0] high_cnt_q, high_cnt_d;
  logic [DataW-1:0] low_cnt_q, low_cnt_d;
  logic [DataW-1:0] pulse_start_q, pulse_start_d;
  logic [DataW-1:0] last_status_q, last_status_d;
  logic [DataW-1:0] acc_cnt_q, acc_cnt_d;
  logic [DataW-1:0] rej_cnt_q, rej_cnt_d;
  logic [DataW-1:0] edge_cnt_q, edge_cnt_d;

  logic [EventW-1:0] event_d;
  logic [DataW-1:0]  width_d;
  logic              status_d;

  // Modular differences against the stored time stamps; the wrap of the
  // free-running timers falls out of 32-bit subtraction.
  logic [DataW-1:0] cal_elapsed, stat_elapsed, pulse_len;
  logic             cal_done, stat_done, width_ok;

  assign cal_elapsed  = s1_ms_q - cal_start_q;
  assign stat_elapsed = s1_ms_q - last_status_q;
  assign pulse_len    = s1_us_q - pulse_start_q;
  assign cal_done     = cal_elapsed >= cal_window_q;
  assign stat_done    = stat_elapsed >= stat_period_q;
  assign width_ok     = (pulse_len >= min_pulse_q) && (pulse_len <= max_pulse_q);

  always_comb begin
    started_d     = started_q;
    calibrated_d  = calibrated_q;
    last_level_d  = last_level_q;
    idle_high_d   = idle_high_q;
    in_pulse_d    = in_pulse_q;
    cal_start_d   = cal_start_q;
    high_cnt_d    = high_cnt_q;
    low_cnt_d     = low_cnt_q;
    pulse_start_d = pulse_start_q;
    last_status_d = last_status_q;
    acc_cnt_d     = acc_cnt_q;
    rej_cnt_d     = rej_cnt_q;
    edge_cnt_d    = edge_cnt_q;
    event_d       = EvNone;
    width_d       = '0;
    status_d      = 1'b0;

    priority if (!started_q) begin
      // The first sample only fixes the reference times and level.
      started_d     = 1'b1;
      last_level_d  = s1_level_q;
      cal_start_d   = s1_ms_q;
      last_status_d = s1_ms_q;
    end else if (!calibrated_q) begin
      if (s1_level_q) begin
        high_cnt_d = high_cnt_q + 1'b1;
      end else begin
        low_cnt_d = low_cnt_q + 1'b1;
      end
      if (cal_done) begin
        // Majority vote decides idle; a tie counts as high.
        idle_high_d   = high_cnt_d >= low_cnt_d;
        last_level_d  = s1_level_q;
        calibrated_d  = 1'b1;
        last_status_d = s1_ms_q;
      end
    end else begin
      if (s1_level_q != last_level_q) begin
        edge_cnt_d   = edge_cnt_q + 1'b1;
        last_level_d = s1_level_q;
        if (s1_level_q != idle_high_q) begin
          in_pulse_d    = 1'b1;
          pulse_start_d = s1_us_q;
        end else if (in_pulse_q) begin
          in_pulse_d = 1'b0;
          width_d    = pulse_len;
          if (width_ok) begin
            acc_cnt_d = acc_cnt_q + 1'b1;
            event_d   = EvAccept;
          end else begin
            rej_cnt_d = rej_cnt_q + 1'b1;
            event_d   = EvReject;
          end
        end
      end
      if (stat_done) begin
        last_status_d = s1_ms_q;
        status_d      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q     <= 1'b0;
      calibrated_q  <= 1'b0;
      last_level_q  <= 1'b0;
      idle_high_q   <= 1'b0;
      in_pulse_q    <= 1'b0;
      cal_start_q   <= '0;
      high_cnt_q    <= '0;
      low_cnt_q     <= '0;
      pulse_start_q <= '0;
      last_status_q <= '0;
      acc_cnt_q     <= '0;
      rej_cnt_q     <= '0;
      edge_cnt_q    <= '0;
    end else if (eval_fire) begin
      started_q     <= started_d;
      calibrated_q  <= calibrated_d;
      last_level_q  <= last_level_d;
      idle_high_q   <= idle_high_d;
      in_pulse_q    <= in_pulse_d;
      cal_start_q   <= cal_start_d;
      high_cnt_q    <= high_cnt_d;
      low_cnt_q     <= low_cnt_d;
      pulse_start_q <= pulse_start_d;
      last_status_q <= last_status_d;
      acc_cnt_q     <= acc_cnt_d;
      rej_cnt_q     <= rej_cnt_d;
      edge_cnt_q    <= edge_cnt_d;
    end
  end

  // Output register.
  logic              o_cal_q, o_idle_q, o_status_q;
  logic [EventW-1:0] o_event_q;
  logic [DataW-1:0]  o_width_q, o_acc_q, o_rej_q, o_edge_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eval_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_fire) begin
      o_cal_q    <= calibrated_d;
      o_idle_q   <= idle_high_d;
      o_event_q  <= event_d;
      o_width_q  <= width_d;
      o_acc_q    <= acc_cnt_d;
      o_rej_q    <= rej_cnt_d;
      o_edge_q   <= edge_cnt_d;
      o_status_q <= status_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign is_calibrated_o  = o_cal_q;
  assign idle_is_high_o   = o_idle_q;
  assign pulse_event_o    = o_event_q;
  assign pulse_width_us_o = o_width_q;
  assign accepted_count_o = o_acc_q;
  assign rejected_count_o = o_rej_q;
  assign edge_count_o     = o_edge_q;
  assign status_due_o     = o_status_q;

endmodule

### rtl/pwqa_checker.sv
// ---------------------------------------------------------------------------
// pwqa_checker
// Port-level checks on the pulse width qualifier, bound to the top level.
// ---------------------------------------------------------------------------
`include "pulse_width_qualifier_autocal_macros.svh"

module pwqa_checker
  import pwqa_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               is_calibrated_o,
  input logic               idle_is_high_o,
  input logic [EventW-1:0]  pulse_event_o,
  input logic [DataW-1:0]   pulse_width_us_o,
  input logic [DataW-1:0]   accepted_count_o,
  input logic [DataW-1:0]   rejected_count_o,
  input logic [DataW-1:0]   edge_count_o,
  input logic               status_due_o
);

  // The whole result beat as one vector, and the conditions on its fields.
  logic                            held;
  logic [3+EventW+4*DataW-1:0]     shown;
  logic                            zero_width_ok;
  logic                            event_legal;

  assign held          = out_valid_o && out_stall_i;
  assign shown         = {is_calibrated_o, idle_is_high_o, pulse_event_o, pulse_width_us_o,
                          accepted_count_o, rejected_count_o, edge_count_o, status_due_o};
  assign zero_width_ok = (pulse_event_o != EvNone) || (pulse_width_us_o == '0);
  assign event_legal   = pulse_event_o <= EvReject;

  // A stalled result beat stays on the port unchanged.
  `PWQA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, held, out_valid_o && $stable(shown))

  // The input side only backs up while a result is waiting on a stalled output.
  `PWQA_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, in_stall_o, held)

  // Once calibrated, every later result still reports calibration.
  `PWQA_ASSERT_NEXT(a_cal_sticky, clk_i, rst_ni, out_valid_o && is_calibrated_o, is_calibrated_o)

  // A result without a finished pulse carries zero width, and the event code is legal.
  `PWQA_ASSERT_IMPL(a_event_width, clk_i, rst_ni, out_valid_o, zero_width_ok && event_legal)

endmodule

bind pulse_width_qualifier_autocal pwqa_checker u_pwqa_checker (.*);

### verif/pulse_verdict_checker.sv
// ----------------------------------------------------------------------------
// Pulse verdict checker
// Watches the register port and both channels of the pulse width qualifier.
// It predicts one result beat per accepted sample beat and compares each
// result beat, field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module pulse_verdict_checker
  import pwqa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DataW-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               sample_level_i,
  input  logic [DataW-1:0]   time_ms_i,
  input  logic [DataW-1:0]   time_us_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               is_calibrated_i,
  input  logic               idle_is_high_i,
  input  logic [EventW-1:0]  pulse_event_i,
  input  logic [DataW-1:0]   pulse_width_us_i,
  input  logic [DataW-1:0]   accepted_count_i,
  input  logic [DataW-1:0]   rejected_count_i,
  input  logic [DataW-1:0]   edge_count_i,
  input  logic               status_due_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              calibrated;
    logic              idle_high;
    logic [EventW-1:0] verdict;
    logic [DataW-1:0]  len_us;
    logic [DataW-1:0]  n_accepted;
    logic [DataW-1:0]  n_rejected;
    logic [DataW-1:0]  n_edges;
    logic              status;
  } verdict_t;

  // Register copies.
  logic [DataW-1:0] window_ms, period_ms, min_us, max_us;

  // Behavioural state of the qualifier.
  logic             seen_first, calibrated, prev_level, idle_ref, pulse_open;
  logic [DataW-1:0] cal_origin_ms, high_cnt, low_cnt, pulse_origin_us;
  logic [DataW-1:0] status_mark_ms, acc_total, rej_total, edge_total;

  verdict_t    pending_verdicts[$];
  verdict_t    want, got;
  int unsigned fails   = 0;
  int unsigned checked = 0;

  function automatic verdict_t predict_verdict(input logic lvl,
                                               input logic [DataW-1:0] ms,
                                               input logic [DataW-1:0] us);
    verdict_t         v;
    logic [DataW-1:0] elapsed;
    v = '0;
    if (!seen_first) begin
      seen_first     = 1'b1;
      prev_level     = lvl;
      cal_origin_ms  = ms;
      status_mark_ms = ms;
    end else if (!calibrated) begin
      if (lvl) begin
        high_cnt = high_cnt + 1'b1;
      end else begin
        low_cnt = low_cnt + 1'b1;
      end
      elapsed = ms - cal_origin_ms;
      if (elapsed >= window_ms) begin
        // A tie between the two counts settles on a high idle level.
        idle_ref       = (high_cnt >= low_cnt);
        prev_level     = lvl;
        calibrated     = 1'b1;
        status_mark_ms = ms;
      end
    end else begin
      if (lvl != prev_level) begin
        edge_total = edge_total + 1'b1;
        if (lvl != idle_ref) begin
          pulse_open      = 1'b1;
          pulse_origin_us = us;
        end else if (pulse_open) begin
          v.len_us   = us - pulse_origin_us;
          pulse_open = 1'b0;
          if (v.len_us >= min_us && v.len_us <= max_us) begin
            acc_total = acc_total + 1'b1;
            v.verdict = EvAccept;
          end else begin
            rej_total = rej_total + 1'b1;
            v.verdict = EvReject;
          end
        end
        prev_level = lvl;
      end
      elapsed = ms - status_mark_ms;
      if (elapsed >= period_ms) begin
        status_mark_ms = ms;
        v.status       = 1'b1;
      end
    end
    v.calibrated = calibrated;
    v.idle_high  = idle_ref;
    v.n_accepted = acc_total;
    v.n_rejected = rej_total;
    v.n_edges    = edge_total;
    return v;
  endfunction

  function automatic string describe_verdict(input verdict_t v);
    return {$sformatf("cal=%0b idle=%0b event=%0d width=%0d ",
                      v.calibrated, v.idle_high, v.verdict, v.len_us),
            $sformatf("acc=%0d rej=%0d edges=%0d status=%0b",
                      v.n_accepted, v.n_rejected, v.n_edges, v.status)};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_ms       = CalWindowRst;
      period_ms       = StatPeriodRst;
      min_us          = MinPulseRst;
      max_us          = MaxPulseRst;
      seen_first      = 1'b0;
      calibrated      = 1'b0;
      prev_level      = 1'b0;
      idle_ref        = 1'b0;
      pulse_open      = 1'b0;
      cal_origin_ms   = '0;
      high_cnt        = '0;
      low_cnt         = '0;
      pulse_origin_us = '0;
      status_mark_ms  = '0;
      acc_total       = '0;
      rej_total       = '0;
      edge_total      = '0;
      pending_verdicts.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgCalWindow:  window_ms = cfg_wdata_i;
          CfgStatPeriod: period_ms = cfg_wdata_i;
          CfgMinPulse:   min_us    = cfg_wdata_i;
          CfgMaxPulse:   max_us    = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        pending_verdicts.push_back(predict_verdict(sample_level_i, time_ms_i, time_us_i));
      end
      if (out_valid_i && !out_stall_i) begin
        got.calibrated = is_calibrated_i;
        got.idle_high  = idle_is_high_i;
        got.verdict    = pulse_event_i;
        got.len_us     = pulse_width_us_i;
        got.n_accepted = accepted_count_i;
        got.n_rejected = rejected_count_i;
        got.n_edges    = edge_count_i;
        got.status     = status_due_i;
        if (pending_verdicts.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("%0t: result beat with no sample outstanding: %s", $time,
                     describe_verdict(got));
          end
        end else begin
          want = pending_verdicts.pop_front();
          checked++;
          if (got !== want) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: mismatch on result beat %0d", $time, checked);
              $display("  expected %s", describe_verdict(want));
              $display("  actual   %s", describe_verdict(got));
            end
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= pending_verdicts.size();
    checked_o    <= checked;
  end

endmodule

### verif/pulse_width_qualifier_autocal_tb.sv
// ----------------------------------------------------------------------------
// Pulse width qualifier testbench
// Drives timestamped sensor samples into the qualifier through a directed
// calibration and pulse sequence, then through several register settings
// with random pulse trains and noise, while the checker predicts every
// result beat. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module pulse_width_qualifier_autocal_tb
  import pwqa_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Roughly 1500 samples spread over the random phases.
  localparam int unsigned PhaseSamples = 185;
  localparam int unsigned NumPhases    = 8;
  // Far above the slowest correct run: every beat waiting out the longest
  // sender gap and the longest receiver stall, plus the drains between phases.
  localparam int unsigned CycleLimit   = 500_000;
  // An index outside the register map; a write to it must change nothing.
  localparam logic [CfgIdxW-1:0] CfgUnusedIdx = 8'd200;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [DataW-1:0]   cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               sample_level_i;
  logic [DataW-1:0]   time_ms_i;
  logic [DataW-1:0]   time_us_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               is_calibrated_o;
  logic               idle_is_high_o;
  logic [EventW-1:0]  pulse_event_o;
  logic [DataW-1:0]   pulse_width_us_o;
  logic [DataW-1:0]   accepted_count_o;
  logic [DataW-1:0]   rejected_count_o;
  logic [DataW-1:0]   edge_count_o;
  logic               status_due_o;

  int unsigned fail_count, pending, checked;

  // Stimulus bookkeeping: the current time bases, the pulse limits in force
  // (used to aim pulse widths at the boundaries) and the idling modes.
  logic [DataW-1:0] cur_ms, cur_us, cur_min, cur_max;
  int unsigned      samples_sent  = 0;
  int unsigned      settings_used = 0;
  int unsigned      cycle_count   = 0;
  bit               send_burst    = 1'b0;
  bit               take_burst    = 1'b0;

  pulse_width_qualifier_autocal dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_level_i  (sample_level_i),
    .time_ms_i       (time_ms_i),
    .time_us_i       (time_us_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .is_calibrated_o (is_calibrated_o),
    .idle_is_high_o  (idle_is_high_o),
    .pulse_event_o   (pulse_event_o),
    .pulse_width_us_o(pulse_width_us_o),
    .accepted_count_o(accepted_count_o),
    .rejected_count_o(rejected_count_o),
    .edge_count_o    (edge_count_o),
    .status_due_o    (status_due_o)
  );

  pulse_verdict_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .sample_level_i  (sample_level_i),
    .time_ms_i       (time_ms_i),
    .time_us_i       (time_us_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .is_calibrated_i (is_calibrated_o),
    .idle_is_high_i  (idle_is_high_o),
    .pulse_event_i   (pulse_event_o),
    .pulse_width_us_i(pulse_width_us_o),
    .accepted_count_i(accepted_count_o),
    .rejected_count_i(rejected_count_o),
    .edge_count_i    (edge_count_o),
    .status_due_i    (status_due_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  always #1 clk_i = ~clk_i;

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Run stopped after %0d cycles with %0d results outstanding", CycleLimit,
               pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // The next millisecond stamp: mostly small steps, sometimes a jump far
  // enough to trip the status period, and now and then anywhere at all, so
  // that the wrap-around of the time base is crossed in both directions.
  function automatic logic [DataW-1:0] next_ms();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) begin
      return $urandom;
    end else if (r < 12) begin
      return cur_ms + $urandom_range(0, 2000);
    end
    return cur_ms + $urandom_range(0, 3);
  endfunction

  function automatic logic [DataW-1:0] next_us();
    if ($urandom_range(0, 99) < 3) begin
      return $urandom;
    end
    return cur_us + $urandom_range(0, 600);
  endfunction

  // Offers one sample beat after a random gap and holds it until it is taken.
  // The valid stays high from one beat to the next when no gap is drawn.
  task automatic send_sample(input logic lvl, input logic [DataW-1:0] ms,
                             input logic [DataW-1:0] us);
    int unsigned gap;
    if ($urandom_range(0, 29) == 0) begin
      send_burst = !send_burst;
    end
    gap = send_burst ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_level_i <= lvl;
    time_ms_i      <= ms;
    time_us_i      <= us;
    cur_ms = ms;
    cur_us = us;
    samples_sent++;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stops sending and waits until every predicted result beat has arrived.
  // Each sample produces a result, so an empty prediction store means the
  // pipeline is empty; a few more cycles give some slack on top.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes all four registers in index order, optionally followed by a write
  // to an index outside the map, on consecutive clock edges.
  task automatic set_config(input logic [DataW-1:0] win, input logic [DataW-1:0] per,
                            input logic [DataW-1:0] mn, input logic [DataW-1:0] mx,
                            input bit with_unused);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgCalWindow;
    cfg_wdata_i <= win;
    @(posedge clk_i);
    cfg_idx_i   <= CfgStatPeriod;
    cfg_wdata_i <= per;
    @(posedge clk_i);
    cfg_idx_i   <= CfgMinPulse;
    cfg_wdata_i <= mn;
    @(posedge clk_i);
    cfg_idx_i   <= CfgMaxPulse;
    cfg_wdata_i <= mx;
    @(posedge clk_i);
    if (with_unused) begin
      cfg_idx_i   <= CfgUnusedIdx;
      cfg_wdata_i <= $urandom;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cur_min = mn;
    cur_max = mx;
    settings_used++;
  endtask

  // A well-formed pulse around a high idle level: some idle samples, a low
  // start, some low samples, then the return to idle with a width aimed at
  // the limits in force, at random inside them, or far outside them.
  task automatic send_pulse();
    logic [DataW-1:0] origin, width;
    repeat ($urandom_range(0, 3)) send_sample(1'b1, next_ms(), next_us());
    origin = next_us();
    send_sample(1'b0, next_ms(), origin);
    repeat ($urandom_range(0, 3)) send_sample(1'b0, next_ms(), origin + $urandom_range(0, 200));
    case ($urandom_range(0, 7))
      0: width = cur_min - 1'b1;
      1: width = cur_min;
      2: width = cur_max;
      3: width = cur_max + 1'b1;
      4: width = (cur_min <= cur_max) ? cur_min + $urandom_range(0, cur_max - cur_min)
                                      : $urandom;
      5: width = $urandom_range(0, 50);
      6: width = $urandom;
      default: width = '0;
    endcase
    send_sample(1'b1, next_ms(), origin + width);
  endtask

  // Random levels: glitches, doubled edges and pulses broken off mid-way.
  task automatic send_noise();
    repeat ($urandom_range(1, 4)) send_sample(1'($urandom_range(0, 1)), next_ms(), next_us());
  endtask

  task automatic run_traffic(input int unsigned budget);
    int unsigned first;
    first = samples_sent;
    while (samples_sent - first < budget) begin
      if ($urandom_range(0, 9) < 7) begin
        send_pulse();
      end else begin
        send_noise();
      end
    end
  endtask

  // The receiver draws a stall length for each result beat, holds the stall
  // that long and then takes the next beat offered. Stretches without any
  // stall come from the burst mode, which toggles at random.
  initial begin : result_sink
    int unsigned hold;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 29) == 0) begin
        take_burst = !take_burst;
      end
      hold = take_burst ? 0 : $urandom_range(0, 10);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  initial begin : stimulus
    int unsigned ph;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= CfgCalWindow;
    cfg_wdata_i    <= '0;
    in_valid_i     <= 1'b0;
    sample_level_i <= 1'b0;
    time_ms_i      <= '0;
    time_us_i      <= '0;
    cur_ms = '0;
    cur_us = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The widest calibration window: it only closes when the millisecond
    // stamp has come all the way round to one below the start time.
    set_config(32'hFFFF_FFFF, StatPeriodRst, MinPulseRst, MaxPulseRst, 1'b0);

    // The first sample only records the start; it is not counted.
    send_sample(1'b1, 32'd0, 32'hFFFF_FFFF);
    // Calibration: two high and two low samples, so the tie picks a high
    // idle level, and the closing sample leaves the last level low.
    send_sample(1'b1, 32'd1, 32'd0);
    send_sample(1'b0, 32'd2, 32'd10);
    send_sample(1'b1, 32'd3, 32'd20);
    send_sample(1'b0, 32'hFFFF_FFFF, 32'd30);
    // Back to idle with no pulse under way: an edge and nothing more.
    send_sample(1'b1, 32'd0, 32'd40);
    // Exactly the minimum width, accepted; one below it, rejected.
    send_sample(1'b0, 32'd1, 32'd100);
    send_sample(1'b1, 32'd2, 32'd400);
    send_sample(1'b0, 32'd3, 32'd1000);
    send_sample(1'b1, 32'd4, 32'd1299);
    // Exactly the maximum with a repeated level inside, then one above it.
    send_sample(1'b0, 32'd5, 32'd2000);
    send_sample(1'b0, 32'd6, 32'd2100);
    send_sample(1'b1, 32'd7, 32'd102000);
    send_sample(1'b0, 32'd8, 32'd200000);
    send_sample(1'b1, 32'd9, 32'd300001);
    // A pulse across the microsecond wrap, measured modulo 2^32.
    send_sample(1'b0, 32'd10, 32'hFFFF_FF00);
    send_sample(1'b1, 32'd998, 32'h0000_0100);
    // One full status period after the end of calibration.
    send_sample(1'b1, 32'd999, 32'h0000_0200);
    // A pulse of zero width.
    send_sample(1'b0, 32'd1000, 32'd0);
    send_sample(1'b1, 32'd1001, 32'd0);
    wait_for_results();

    for (ph = 1; ph <= NumPhases; ph++) begin
      case (ph)
        // Zero window and zero period: status on every sample, and limits
        // wide open so that every pulse passes.
        1: set_config('0, '0, '0, 32'hFFFF_FFFF, 1'b0);
        // The longest period, and a minimum above the maximum. The previous
        // phase left the status mark at the current stamp, so a stamp one
        // below it is exactly one full period later.
        2: begin
          set_config($urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd200, 1'b0);
          send_sample(1'b1, cur_ms - 1'b1, next_us());
        end
        // Only a zero width is accepted.
        3: set_config($urandom, 32'd1, '0, '0, 1'b0);
        4: begin
          cur_min = $urandom_range(0, 100);
          set_config($urandom, $urandom_range(1, 200), cur_min,
                     cur_min + $urandom_range(0, 5000), 1'b0);
        end
        // Reset values again, with a stray write that must be ignored.
        5: set_config(CalWindowRst, StatPeriodRst, MinPulseRst, MaxPulseRst, 1'b1);
        6: set_config($urandom, $urandom_range(1, 3000), $urandom_range(0, 2000), $urandom,
                      1'b0);
        7: set_config($urandom, $urandom, $urandom, $urandom, 1'b1);
        default: set_config($urandom, StatPeriodRst, MinPulseRst, MaxPulseRst, 1'b0);
      endcase
      run_traffic(PhaseSamples);
      wait_for_results();
    end

    repeat (10) @(posedge clk_i);
    $display("Covered %0d samples and %0d checked result beats under %0d register settings,",
             samples_sent, checked, settings_used);
    $display("with calibration, time wraps, boundary widths and extreme periods and limits.");
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
